/* hdl/tcp_connection_tracker_defines.svh */
// ----------------------------------------------------------------------------
// tcp_connection_tracker_defines
// Assertion macros used by the checker file, tct_checker.
// ----------------------------------------------------------------------------
`ifndef TCP_CONNECTION_TRACKER_DEFINES_SVH
`define TCP_CONNECTION_TRACKER_DEFINES_SVH

// Assert that a condition implies a property in the same cycle.
`define TCT_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Assert that a condition implies a property in the next cycle.
`define TCT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hdl/tct_pkg.sv */
// ----------------------------------------------------------------------------
// tct_pkg
// Types, codes and constants for the TCP connection tracker.
// ----------------------------------------------------------------------------
package tct_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 16;
   localparam logic [1:0]  LEVEL_EST       = 2'd3;

   localparam logic [7:0] FL_FIN = 8'h01;
   localparam logic [7:0] FL_SYN = 8'h02;
   localparam logic [7:0] FL_RST = 8'h04;
   localparam logic [7:0] FL_ACK = 8'h10;

   localparam logic [1:0] NET_IPV4 = 2'd1;
   localparam logic [1:0] NET_IPV6 = 2'd2;

   localparam logic [2:0] ST_DROPPED = 3'd0;
   localparam logic [2:0] ST_MATCHED = 3'd1;
   localparam logic [2:0] ST_CREATED = 3'd2;
   localparam logic [2:0] ST_NOCREATE = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic [2:0] CSR_NAT_EN   = 3'd0;
   localparam logic [2:0] CSR_NAT4_A   = 3'd1;
   localparam logic [2:0] CSR_NAT4_M   = 3'd2;
   localparam logic [2:0] CSR_NAT6_AH  = 3'd3;
   localparam logic [2:0] CSR_NAT6_AL  = 3'd4;
   localparam logic [2:0] CSR_NAT6_MH  = 3'd5;
   localparam logic [2:0] CSR_NAT6_ML  = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_WRITE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        ipv6;
      logic [63:0] a_hi;
      logic [63:0] a_lo;
      logic [63:0] b_hi;
      logic [63:0] b_lo;
      logic [15:0] port_a;
      logic [15:0] port_b;
      logic [31:0] seq_a;
      logic [31:0] seq_b;
      logic [1:0]  syn_lvl;
      logic [1:0]  cls_lvl;
      logic [31:0] count;
      logic [31:0] ident;
   } entry_type;

   typedef struct packed {
      logic [31:0] count;
      logic [1:0]  syn_lvl;
      logic [1:0]  cls_lvl;
      logic        closes;
   } hit_type;

   function automatic hit_type hit_update(input logic [31:0] count,
                                          input logic [1:0] syn_lvl,
                                          input logic [1:0] cls_lvl,
                                          input logic [7:0] flags);
      hit_type h;
      h.count   = (count != '1) ? count + 32'd1 : count;
      h.syn_lvl = syn_lvl;
      h.cls_lvl = cls_lvl;
      if ((flags & FL_SYN) != 0 && (flags & FL_ACK) != 0 && h.syn_lvl == 2'd1)
         h.syn_lvl = 2'd2;
      if ((flags & FL_ACK) != 0 && h.syn_lvl == 2'd2)
         h.syn_lvl = LEVEL_EST;
      if (h.count >= 32'd3)
         h.syn_lvl = LEVEL_EST;
      if ((flags & FL_ACK) != 0 && h.cls_lvl == 2'd1)
         h.cls_lvl = 2'd2;
      if ((flags & FL_FIN) != 0)
         h.cls_lvl = 2'd1;
      h.closes = (h.cls_lvl == 2'd2) || ((flags & FL_RST) != 0);
      return h;
   endfunction

endpackage

/* hdl/tct_table.sv */
// ----------------------------------------------------------------------------
// tct_table
// Connection entry memory: one write port, one registered read port, and
// the per-entry valid bits in flip-flops.
// ----------------------------------------------------------------------------
module tct_table #(
   parameter int unsigned TABLE_DEPTH = tct_pkg::TABLE_DEPTH_DEF,
   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [AW-1:0]       rd_addr,
   output tct_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tct_pkg::entry_type  wr_data,
   input  logic                vld_set,
   input  logic                vld_clr,
   input  logic [AW-1:0]       vld_addr,
   output logic [TABLE_DEPTH-1:0] valid
);

   tct_pkg::entry_type mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (vld_set) begin
         valid_ff[vld_addr] <= 1'b1;
      end else if (vld_clr) begin
         valid_ff[vld_addr] <= 1'b0;
      end
   end

   assign valid = valid_ff;

endmodule

/* hdl/tcp_connection_tracker.sv */
// ----------------------------------------------------------------------------
// tcp_connection_tracker
// Per-packet TCP flow table: match, update, create and free connections.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | beat
//  req_    | in        | req_valid/req_ready | one packet header
//  rsp_    | out       | rsp_valid/rsp_ready | one result per packet
//  csr_    | in        | csr_valid/csr_ready | register index and data
//
// The match walks the entry memory one entry at a time (read, then compare)
// until a hit or the last entry, then write-back and output states. Dropped
// packets go straight to the output state. Packets are taken only in idle.
// Reset clears the valid bits. A stalled result holds the output state.
// ----------------------------------------------------------------------------
module tcp_connection_tracker #(
   parameter int unsigned TABLE_DEPTH = tct_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_tcp,
   input  logic [1:0]  req_net_type,
   input  logic [63:0] req_src_hi,
   input  logic [63:0] req_src_lo,
   input  logic [63:0] req_dst_hi,
   input  logic [63:0] req_dst_lo,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [31:0] req_seq_num,
   input  logic [31:0] req_ack_num,
   input  logic [7:0]  req_tcp_flags,
   input  logic        req_has_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [31:0] rsp_conn_id,
   output logic        rsp_reverse,
   output logic [1:0]  rsp_handshake_level,
   output logic [1:0]  rsp_fin_level,
   output logic        rsp_closed,
   output logic [31:0] rsp_packet_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   tct_pkg::state_type state_ff, state_in;

   logic [1:0]  nat_en_ff;
   logic [31:0] nat4_a_ff, nat4_m_ff;
   logic [63:0] nat6_ah_ff, nat6_al_ff, nat6_mh_ff, nat6_ml_ff;

   // captured packet
   logic        v6_ff;
   logic [63:0] shi_ff, slo_ff, dhi_ff, dlo_ff;
   logic [15:0] sp_ff, dp_ff;
   logic [31:0] seq_ff, ack_ff;
   logic [7:0]  flg_ff;
   logic        pay_ff;

   logic [CW-1:0] idx_ff, idx_in;   // address being read
   logic [AW-1:0] chk_ff, chk_in;   // address whose data is on rd_data
   logic [31:0]   next_id_ff;

   tct_pkg::entry_type rd_data, wr_data_ff;
   logic [TABLE_DEPTH-1:0] valid;
   logic          wr_en_ff, vset_ff, vclr_ff;
   logic [AW-1:0] wr_addr_ff;

   logic [2:0]  o_status_ff;
   logic [3:0]  o_slot_ff;
   logic [31:0] o_id_ff, o_cnt_ff;
   logic        o_rev_ff, o_closed_ff;
   logic [1:0]  o_syn_ff, o_cls_ff;

   logic        accept, drop, fwd_hit, bwd_hit, hit, last;
   logic        any_free;
   logic [AW-1:0] free_idx;
   logic        nat_on, s_in, d_in, rev_new;
   logic [1:0]  syn_new;
   tct_pkg::hit_type h_hit, h_new;
   tct_pkg::entry_type new_e, upd_e;

   assign accept = req_valid && req_ready;
   assign drop   = !req_is_tcp
                   || (req_net_type != tct_pkg::NET_IPV4 && req_net_type != tct_pkg::NET_IPV6)
                   || req_src_port == 16'd0 || req_dst_port == 16'd0;

   tct_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .vld_set (vset_ff),
      .vld_clr (vclr_ff),
      .vld_addr(wr_addr_ff),
      .valid   (valid)
   );

   // match of the entry whose data has come back
   always_comb begin
      fwd_hit = rd_data.a_hi == shi_ff && rd_data.a_lo == slo_ff;
      bwd_hit = !fwd_hit && rd_data.b_hi == shi_ff && rd_data.b_lo == slo_ff;
      hit = valid[chk_ff] && rd_data.ipv6 == v6_ff &&
            ((fwd_hit && rd_data.b_hi == dhi_ff && rd_data.b_lo == dlo_ff &&
              sp_ff == rd_data.port_a && dp_ff == rd_data.port_b) ||
             (bwd_hit && rd_data.a_hi == dhi_ff && rd_data.a_lo == dlo_ff &&
              sp_ff == rd_data.port_b && dp_ff == rd_data.port_a));
      last = (CW'(chk_ff) == CW'(TABLE_DEPTH - 1));
      h_hit = tct_pkg::hit_update(rd_data.count, rd_data.syn_lvl, rd_data.cls_lvl, flg_ff);
      upd_e = rd_data;
      upd_e.count   = h_hit.count;
      upd_e.syn_lvl = h_hit.syn_lvl;
      upd_e.cls_lvl = h_hit.cls_lvl;
   end

   // lowest free entry
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            any_free = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   // new entry
   always_comb begin
      nat_on = v6_ff ? nat_en_ff[1] : nat_en_ff[0];
      if (v6_ff) begin
         s_in = ((shi_ff ^ nat6_ah_ff) & nat6_mh_ff) == 0 &&
                ((slo_ff ^ nat6_al_ff) & nat6_ml_ff) == 0;
         d_in = ((dhi_ff ^ nat6_ah_ff) & nat6_mh_ff) == 0 &&
                ((dlo_ff ^ nat6_al_ff) & nat6_ml_ff) == 0;
      end else begin
         s_in = ((slo_ff[31:0] ^ nat4_a_ff) & nat4_m_ff) == 0;
         d_in = ((dlo_ff[31:0] ^ nat4_a_ff) & nat4_m_ff) == 0;
      end
      if ((flg_ff & tct_pkg::FL_SYN) != 0 && (flg_ff & tct_pkg::FL_ACK) == 0) begin
         syn_new = 2'd1;
         rev_new = 1'b0;
      end else if ((flg_ff & tct_pkg::FL_SYN) != 0) begin
         syn_new = 2'd2;
         rev_new = 1'b1;
      end else begin
         syn_new = tct_pkg::LEVEL_EST;
         if (nat_on && s_in != d_in) begin
            rev_new = d_in;
         end else begin
            rev_new = !(sp_ff > dp_ff);
         end
      end
      new_e.ipv6    = v6_ff;
      new_e.a_hi    = rev_new ? dhi_ff : shi_ff;
      new_e.a_lo    = rev_new ? dlo_ff : slo_ff;
      new_e.b_hi    = rev_new ? shi_ff : dhi_ff;
      new_e.b_lo    = rev_new ? slo_ff : dlo_ff;
      new_e.port_a  = rev_new ? dp_ff : sp_ff;
      new_e.port_b  = rev_new ? sp_ff : dp_ff;
      new_e.seq_a   = rev_new ? ack_ff : seq_ff;
      new_e.seq_b   = rev_new ? seq_ff : 32'd0;
      new_e.ident   = next_id_ff;
      h_new = tct_pkg::hit_update(32'd1, syn_new, 2'd0, flg_ff);
      new_e.count   = pay_ff ? h_new.count : 32'd1;
      new_e.syn_lvl = pay_ff ? h_new.syn_lvl : syn_new;
      new_e.cls_lvl = pay_ff ? h_new.cls_lvl : 2'd0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tct_pkg::S_IDLE: begin
            if (accept) begin
               state_in = drop ? tct_pkg::S_OUT : tct_pkg::S_READ;
            end
         end
         tct_pkg::S_READ:  state_in = tct_pkg::S_CHECK;
         tct_pkg::S_CHECK: begin
            if (hit || last) begin
               state_in = tct_pkg::S_WRITE;
            end else begin
               state_in = tct_pkg::S_READ;
            end
         end
         tct_pkg::S_WRITE: state_in = tct_pkg::S_OUT;
         tct_pkg::S_OUT: begin
            if (rsp_ready) begin
               state_in = tct_pkg::S_IDLE;
            end
         end
         default: state_in = tct_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == tct_pkg::S_IDLE) && !csr_valid;
      csr_ready = (state_ff == tct_pkg::S_IDLE);
      rsp_valid = (state_ff == tct_pkg::S_OUT);
      idx_in = idx_ff;
      chk_in = chk_ff;
      if (state_ff == tct_pkg::S_IDLE) begin
         idx_in = '0;
      end else if (state_ff == tct_pkg::S_READ) begin
         chk_in = idx_ff[AW-1:0];
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tct_pkg::S_IDLE;
         next_id_ff <= '0;
         nat_en_ff  <= '0;
         nat4_a_ff  <= '0;
         nat4_m_ff  <= '0;
         nat6_ah_ff <= '0;
         nat6_al_ff <= '0;
         nat6_mh_ff <= '0;
         nat6_ml_ff <= '0;
         wr_en_ff   <= 1'b0;
         vset_ff    <= 1'b0;
         vclr_ff    <= 1'b0;
         idx_ff     <= '0;
         chk_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         chk_ff   <= chk_in;
         wr_en_ff <= 1'b0;
         vset_ff  <= 1'b0;
         vclr_ff  <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tct_pkg::CSR_NAT_EN:  nat_en_ff  <= csr_data[1:0];
               tct_pkg::CSR_NAT4_A:  nat4_a_ff  <= csr_data[31:0];
               tct_pkg::CSR_NAT4_M:  nat4_m_ff  <= csr_data[31:0];
               tct_pkg::CSR_NAT6_AH: nat6_ah_ff <= csr_data;
               tct_pkg::CSR_NAT6_AL: nat6_al_ff <= csr_data;
               tct_pkg::CSR_NAT6_MH: nat6_mh_ff <= csr_data;
               tct_pkg::CSR_NAT6_ML: nat6_ml_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == tct_pkg::S_CHECK && hit) begin
            wr_en_ff   <= 1'b1;
            wr_addr_ff <= chk_ff;
            wr_data_ff <= upd_e;
            vclr_ff    <= h_hit.closes;
         end else if (state_ff == tct_pkg::S_CHECK && last &&
                      (flg_ff & (tct_pkg::FL_FIN | tct_pkg::FL_RST)) == 0 && any_free) begin
            wr_en_ff   <= 1'b1;
            vset_ff    <= 1'b1;
            wr_addr_ff <= free_idx;
            wr_data_ff <= new_e;
            next_id_ff <= next_id_ff + 32'd1;
         end
      end
   end

   // packet capture and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         v6_ff  <= (req_net_type == tct_pkg::NET_IPV6);
         shi_ff <= (req_net_type == tct_pkg::NET_IPV6) ? req_src_hi : 64'd0;
         dhi_ff <= (req_net_type == tct_pkg::NET_IPV6) ? req_dst_hi : 64'd0;
         slo_ff <= (req_net_type == tct_pkg::NET_IPV6) ? req_src_lo
                                                       : {32'd0, req_src_lo[31:0]};
         dlo_ff <= (req_net_type == tct_pkg::NET_IPV6) ? req_dst_lo
                                                       : {32'd0, req_dst_lo[31:0]};
         sp_ff  <= req_src_port;
         dp_ff  <= req_dst_port;
         seq_ff <= req_seq_num;
         ack_ff <= req_ack_num;
         flg_ff <= req_tcp_flags;
         pay_ff <= req_has_payload;
         o_status_ff <= tct_pkg::ST_DROPPED;
         o_slot_ff   <= '0;
         o_id_ff     <= '0;
         o_rev_ff    <= 1'b0;
         o_syn_ff    <= '0;
         o_cls_ff    <= '0;
         o_closed_ff <= 1'b0;
         o_cnt_ff    <= '0;
      end else if (state_ff == tct_pkg::S_CHECK && hit) begin
         o_status_ff <= tct_pkg::ST_MATCHED;
         o_slot_ff   <= 4'(chk_ff);
         o_id_ff     <= rd_data.ident;
         o_rev_ff    <= bwd_hit;
         o_syn_ff    <= h_hit.syn_lvl;
         o_cls_ff    <= h_hit.cls_lvl;
         o_closed_ff <= h_hit.closes;
         o_cnt_ff    <= h_hit.count;
      end else if (state_ff == tct_pkg::S_CHECK && last) begin
         if ((flg_ff & (tct_pkg::FL_FIN | tct_pkg::FL_RST)) != 0) begin
            o_status_ff <= tct_pkg::ST_NOCREATE;
         end else if (!any_free) begin
            o_status_ff <= tct_pkg::ST_FULL;
         end else begin
            o_status_ff <= tct_pkg::ST_CREATED;
            o_slot_ff   <= 4'(free_idx);
            o_id_ff     <= next_id_ff;
            o_rev_ff    <= rev_new;
            o_syn_ff    <= new_e.syn_lvl;
            o_cls_ff    <= new_e.cls_lvl;
            o_cnt_ff    <= new_e.count;
         end
      end
   end

   assign rsp_status          = o_status_ff;
   assign rsp_slot            = o_slot_ff;
   assign rsp_conn_id         = o_id_ff;
   assign rsp_reverse         = o_rev_ff;
   assign rsp_handshake_level = o_syn_ff;
   assign rsp_fin_level       = o_cls_ff;
   assign rsp_closed          = o_closed_ff;
   assign rsp_packet_count    = o_cnt_ff;

endmodule

/* hdl/tct_checker.sv */
// ----------------------------------------------------------------------------
// tct_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "tcp_connection_tracker_defines.svh"

module tct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_slot,
   input logic        rsp_closed,
   input logic [31:0] rsp_packet_count
);

   // one packet in flight: no new beat while a result is pending
   `TCT_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "req taken during rsp")
   // an accepted beat leaves the block busy next cycle
   `TCT_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "not busy")
   // no entry means empty fields
   `TCT_ASSERT_IMP(a_empty, clock, reset, rsp_valid && rsp_status != tct_pkg::ST_MATCHED && rsp_status != tct_pkg::ST_CREATED, rsp_slot == 4'd0 && rsp_packet_count == 32'd0, "fields not zero")
   // only a match can close
   `TCT_ASSERT_IMP(a_close, clock, reset, rsp_valid && rsp_closed, rsp_status == tct_pkg::ST_MATCHED, "close without match")
   // a stalled result holds
   `TCT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "result dropped")

endmodule

bind tcp_connection_tracker tct_checker u_tct_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_slot        (rsp_slot),
   .rsp_closed      (rsp_closed),
   .rsp_packet_count(rsp_packet_count)
);
